// ----- rtl/cfvr_pkg.sv -----
// ----------------------------------------------------------------------------
// cfvr_pkg
// Types, constants and arithmetic helpers for the cell-to-face resampler.
// ----------------------------------------------------------------------------
package cfvr_pkg;

  localparam int MAX_DIM      = 64;
  localparam int PLANE_DEPTH  = 4096;
  localparam int SW           = 32;                       // sample width
  localparam int SIZE_W       = 7;                        // size register width
  localparam int POS_W        = $clog2(MAX_DIM);
  localparam int ADDR_W       = $clog2(PLANE_DEPTH);
  localparam int STRIDE_W     = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int ROW_W        = $clog2(MAX_DIM * (MAX_DIM + 1) + MAX_DIM);
  localparam int IDX_W        = 19;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_W        = 7;
  localparam int EXT_W        = SW + 3;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_DIM);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

  localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI - EXT_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS,
    REG_SIZE_X,
    REG_SIZE_Y,
    REG_SIZE_Z
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_MID,
    PH_LAST
  } phase_t;

  // per-cell control from the sequencer, captured with the request
  typedef struct packed {
    logic                emit;
    logic                first;
    logic                last;
    logic [ROW_W-1:0]    row;
    logic [POS_W-1:0]    fx;
    logic [SIZE_W-1:0]   nx;
    logic [STRIDE_W-1:0] stride;
  } cell_meta_t;

  // one cell's worth of faces, handed to the emitter
  typedef struct packed {
    logic [SW-1:0]       v0;
    logic [SW-1:0]       v1;
    logic [SW-1:0]       v2;
    logic [IDX_W-1:0]    idx;
    logic [STRIDE_W-1:0] stride;
    logic                first;
    logic                last;
  } face_item_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s < SIZE_MIN) r = SIZE_MIN;
    if (s > SIZE_MAX) r = SIZE_MAX;
    return r;
  endfunction

  function automatic logic [SW-1:0] sat_q(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return SW'(r);
  endfunction

  // floor((a + b) / 2)
  function automatic logic [SW-1:0] face_mean(input logic signed [SW-1:0] a,
                                              input logic signed [SW-1:0] b);
    logic signed [EXT_W-1:0] t;
    t = EXT_W'(a) + EXT_W'(b);
    return sat_q(t >>> 1);
  endfunction

  // floor((5*near - inner) / 4) = near + 0.25*(near - inner), saturated
  function automatic logic [SW-1:0] face_extrap(input logic signed [SW-1:0] near,
                                                input logic signed [SW-1:0] inner);
    logic signed [EXT_W-1:0] n;
    logic signed [EXT_W-1:0] t;
    n = EXT_W'(near);
    t = (n <<< 2) + n - EXT_W'(inner);
    return sat_q(t >>> 2);
  endfunction

endpackage

// ----- rtl/cfvr_if.sv -----
// ----------------------------------------------------------------------------
// cfvr_if
// Valid/ready channels: cell samples in, face results out.
// ----------------------------------------------------------------------------
interface cfvr_sample_if import cfvr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] cell_sample;

  modport source (output valid, output cell_sample, input ready);
  modport sink   (input valid, input cell_sample, output ready);
endinterface

interface cfvr_face_if import cfvr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] face_value;
  logic [IDX_W-1:0]     face_index;
  logic                 run_last;

  modport source (output valid, output face_value, output face_index, output run_last,
                  input ready);
  modport sink   (input valid, input face_value, input face_index, input run_last,
                  output ready);
endinterface

// ----- rtl/cfvr_ram.sv -----
// ----------------------------------------------------------------------------
// cfvr_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module cfvr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ----- rtl/cfvr_seq.sv -----
// ----------------------------------------------------------------------------
// cfvr_seq
// Configuration registers, raster position tracking and history addressing.
// ----------------------------------------------------------------------------
module cfvr_seq import cfvr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 advance,
  output cell_meta_t           meta,
  output logic [ADDR_W-1:0]    raddr,
  output logic [ADDR_W-1:0]    waddr
);

  logic [1:0]        axis;
  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic [POS_W-1:0]  pos_x, pos_y, pos_z;
  logic [ADDR_W-1:0] ptr;

  logic [SIZE_W-1:0]   sx, sy, sz, nx, ny, n, p;
  logic [STRIDE_W-1:0] delay;
  logic                wrap_x, wrap_y, wrap_z;

  assign sx = clamp_size(size_x);
  assign sy = clamp_size(size_y);
  assign sz = clamp_size(size_z);

  assign nx = (axis == AXIS_X) ? sx + SIZE_W'(1) : sx;
  assign ny = (axis == AXIS_Y) ? sy + SIZE_W'(1) : sy;

  always_comb begin
    unique case (axis)
      AXIS_X: begin
        n     = sx;
        p     = SIZE_W'(pos_x);
        delay = STRIDE_W'(1);
      end
      AXIS_Y: begin
        n     = sy;
        p     = SIZE_W'(pos_y);
        delay = STRIDE_W'(sx);
      end
      default: begin
        // z, and the no-output code, delay by a plane
        n     = sz;
        p     = SIZE_W'(pos_z);
        delay = STRIDE_W'(STRIDE_W'(sx) * STRIDE_W'(sy));
      end
    endcase
  end

  always_comb begin
    meta.emit   = (axis != AXIS_NONE) && (p != '0);
    meta.first  = (p == SIZE_W'(1));
    meta.last   = (p == n - SIZE_W'(1));
    meta.row    = ROW_W'(pos_z) * ROW_W'(ny) + ROW_W'(pos_y);
    meta.fx     = pos_x;
    meta.nx     = nx;
    meta.stride = delay;
  end

  // a full plane of delay wraps to the entry being overwritten (read-first)
  assign raddr = ptr - ADDR_W'(delay);
  assign waddr = ptr;

  assign wrap_x = (SIZE_W'(pos_x) + SIZE_W'(1)) == sx;
  assign wrap_y = (SIZE_W'(pos_y) + SIZE_W'(1)) == sy;
  assign wrap_z = (SIZE_W'(pos_z) + SIZE_W'(1)) == sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis   <= AXIS_X;
      size_x <= SIZE_RESET;
      size_y <= SIZE_RESET;
      size_z <= SIZE_RESET;
      pos_x  <= '0;
      pos_y  <= '0;
      pos_z  <= '0;
      ptr    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AXIS:   axis   <= cfg_data[1:0];
        REG_SIZE_X: size_x <= cfg_data;
        REG_SIZE_Y: size_y <= cfg_data;
        REG_SIZE_Z: size_z <= cfg_data;
      endcase
      // any write restarts the grid
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
      ptr   <= '0;
    end else if (advance) begin
      ptr <= ptr + ADDR_W'(1);
      if (wrap_x) begin
        pos_x <= '0;
        if (wrap_y) begin
          pos_y <= '0;
          pos_z <= wrap_z ? '0 : pos_z + POS_W'(1);
        end else begin
          pos_y <= pos_y + POS_W'(1);
        end
      end else begin
        pos_x <= pos_x + POS_W'(1);
      end
    end
  end

endmodule

// ----- rtl/cfvr_emit.sv -----
// ----------------------------------------------------------------------------
// cfvr_emit
// Serializes up to three faces per cell into the output register.
// ----------------------------------------------------------------------------
module cfvr_emit import cfvr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  face_item_t    item_in,
  output logic          take,
  cfvr_face_if.source   face
);

  phase_t     phase, phase_next;
  face_item_t item;

  logic                 out_open;
  logic                 emit_now;
  logic                 final_now;
  logic signed [SW-1:0] sel_value;
  logic [IDX_W-1:0]     sel_index;

  assign out_open = !face.valid || face.ready;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (load) phase_next = item_in.first ? PH_FIRST : PH_MID;
      end
      PH_FIRST: begin
        if (out_open) phase_next = PH_MID;
      end
      PH_MID: begin
        if (out_open) begin
          if (item.last)    phase_next = PH_LAST;
          else if (load)    phase_next = item_in.first ? PH_FIRST : PH_MID;
          else              phase_next = PH_IDLE;
        end
      end
      PH_LAST: begin
        if (out_open) phase_next = load ? (item_in.first ? PH_FIRST : PH_MID) : PH_IDLE;
      end
    endcase
  end

  always_comb begin
    emit_now  = (phase != PH_IDLE) && out_open;
    final_now = emit_now && ((phase == PH_LAST) || ((phase == PH_MID) && !item.last));
    take      = (phase == PH_IDLE) || final_now;
    unique case (phase)
      PH_FIRST: begin
        sel_value = item.v0;
        sel_index = item.idx - IDX_W'(item.stride);
      end
      PH_LAST: begin
        sel_value = item.v2;
        sel_index = item.idx + IDX_W'(item.stride);
      end
      default: begin
        sel_value = item.v1;
        sel_index = item.idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      face.valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (emit_now)        face.valid <= 1'b1;
      else if (face.ready) face.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) item <= item_in;
    if (emit_now) begin
      face.face_value <= sel_value;
      face.face_index <= sel_index;
      face.run_last   <= final_now;
    end
  end

endmodule

// ----- rtl/cell_to_face_velocity_resampler.sv -----
// ----------------------------------------------------------------------------
// cell_to_face_velocity_resampler
// Cell-centered samples in, staggered face values along one axis out.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  cells     in   valid/ready      cell_sample
//  face      out  valid/ready      face_value, face_index, run_last
//  cfg       in   cfg_we           cfg_index, cfg_data
//
// One cell per cycle when it makes one face or none and face is ready. The second
// cell along the axis and the last one each add a face (both at once on a two-cell
// axis), and each extra face holds the input back: the emitter feeds a single
// output register, one face a cycle while face is ready.
// A cell's first face is registered in stage 1 and the emitter before output.
// History RAM has no reset or clearing pass; rst clears only control state.
// ----------------------------------------------------------------------------
module cell_to_face_velocity_resampler import cfvr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  cfvr_sample_if.sink          cells,
  cfvr_face_if.source          face
);

  cell_meta_t        meta;
  logic [ADDR_W-1:0] raddr, waddr;
  logic              accept;

  logic              s1_valid;
  logic [SW-1:0]     s1_cur;
  cell_meta_t        s1_meta;
  logic [SW-1:0]     prev;
  logic              s1_move;

  face_item_t        item;
  logic              load;
  logic              take;

  cfvr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .meta      (meta),
    .raddr     (raddr),
    .waddr     (waddr)
  );

  cfvr_ram #(
    .WIDTH (SW),
    .DEPTH (PLANE_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (cells.cell_sample),
    .re    (accept),
    .raddr (raddr),
    .rdata (prev)
  );

  // cells with no face drop out here without touching the emitter
  assign s1_move     = s1_valid && (!s1_meta.emit || take);
  assign cells.ready = !s1_valid || s1_move;
  assign accept      = cells.valid && cells.ready;
  assign load        = s1_move && s1_meta.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur  <= cells.cell_sample;
      s1_meta <= meta;
    end
  end

  always_comb begin
    item.v0     = face_extrap($signed(prev), $signed(s1_cur));
    item.v1     = face_mean($signed(prev), $signed(s1_cur));
    item.v2     = face_extrap($signed(s1_cur), $signed(prev));
    item.idx    = IDX_W'(s1_meta.row) * IDX_W'(s1_meta.nx) + IDX_W'(s1_meta.fx);
    item.stride = s1_meta.stride;
    item.first  = s1_meta.first;
    item.last   = s1_meta.last;
  end

  cfvr_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .item_in (item),
    .take    (take),
    .face    (face)
  );

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted cell did not reach stage 1");

  a_prev_held: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(prev))
    else $error("history read data changed without a new cell");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_meta.emit && !take) |=> (s1_valid && $stable(s1_cur)))
    else $error("stage 1 lost a cell while the emitter was busy");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |-> !cells.ready)
    else $error("cell taken while stage 1 is occupied");

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cell-to-face resampler. Cell samples go in over
// valid/ready in grid phases, each phase opened by register writes while the
// block is idle. A predictor tracks positions, history and configuration and
// queues the faces every accepted cell should produce; the monitor checks
// value, index and the last-face flag of every face request in order.
// ----------------------------------------------------------------------------
module testbench;
  import cfvr_pkg::*;

  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         SETTLE_CYCLES = 12;
  localparam int         HOLD_CYCLES   = 120;
  localparam int         MAX_REPORTS   = 40;
  localparam longint     Q_MAX         = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint     Q_MIN         = -Q_MAX - 1;

  typedef struct packed {
    logic [SW-1:0]    value;
    logic [IDX_W-1:0] index;
    logic             last;
  } face_rec_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic          cell_valid_r = 1'b0;
  logic [SW-1:0] cell_data_r = '0;
  logic          face_ready_r = 1'b0;
  logic          hold_kick = 1'b0;

  int tx_idle_pct = 16;
  int rx_idle_pct = 88;
  int stall_left = 0;
  int mismatches = 0;

  logic [SW-1:0] cell_pending_q[$];
  face_rec_t     expected_faces[$];

  // predictor state
  logic [1:0]        m_axis = AXIS_X;
  logic [SIZE_W-1:0] m_sx = SIZE_RESET;
  logic [SIZE_W-1:0] m_sy = SIZE_RESET;
  logic [SIZE_W-1:0] m_sz = SIZE_RESET;
  logic [SW-1:0]     hist_mem [PLANE_DEPTH];
  logic [ADDR_W-1:0] wr_ptr = '0;
  int unsigned       px = 0, py = 0, pz = 0;

  cfvr_sample_if cell_ch ();
  cfvr_face_if   face_ch ();

  assign cell_ch.valid       = cell_valid_r;
  assign cell_ch.cell_sample = cell_data_r;
  assign face_ch.ready       = face_ready_r;

  cell_to_face_velocity_resampler uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cells     (cell_ch),
    .face      (face_ch)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned eff_dim(input logic [SIZE_W-1:0] s);
    if (s < 2) return 2;
    if (s > MAX_DIM) return MAX_DIM;
    return 32'(s);
  endfunction

  function automatic logic [SW-1:0] clip_q(input longint v);
    if (v > Q_MAX) return SW'(Q_MAX);
    if (v < Q_MIN) return SW'(Q_MIN);
    return SW'(v);
  endfunction

  // faces produced by one accepted cell, in emission order
  task automatic predict_faces(input logic [SW-1:0] raw);
    int unsigned sx, sy, sz, nx, ny, n, p, delay, base, stride, cnt;
    logic [ADDR_W-1:0] rd;
    longint cur, prev;
    face_rec_t faces [3];
    sx = eff_dim(m_sx);
    sy = eff_dim(m_sy);
    sz = eff_dim(m_sz);
    if (px >= sx || py >= sy || pz >= sz) begin
      px = 0;
      py = 0;
      pz = 0;
    end
    nx = sx;
    ny = sy;
    cnt = 0;
    case (m_axis)
      AXIS_X: begin
        n = sx; p = px; delay = 1; nx = sx + 1;
        base = (pz * ny + py) * nx;
        stride = 1;
      end
      AXIS_Y: begin
        n = sy; p = py; delay = sx; ny = sy + 1;
        base = pz * ny * nx + px;
        stride = nx;
      end
      default: begin
        n = sz; p = pz; delay = sx * sy;
        base = py * nx + px;
        stride = nx * ny;
      end
    endcase
    cur = longint'(signed'(raw));
    rd = wr_ptr - ADDR_W'(delay);
    prev = longint'(signed'(hist_mem[rd]));
    hist_mem[wr_ptr] = raw;
    wr_ptr = wr_ptr + ADDR_W'(1);
    if (m_axis != AXIS_NONE && p >= 1) begin
      if (p == 1) begin
        faces[cnt] = {clip_q((5 * prev - cur) >>> 2), IDX_W'(base), 1'b0};
        cnt++;
      end
      faces[cnt] = {clip_q((prev + cur) >>> 1), IDX_W'(base + p * stride), 1'b0};
      cnt++;
      if (p == n - 1) begin
        faces[cnt] = {clip_q((5 * cur - prev) >>> 2), IDX_W'(base + n * stride), 1'b0};
        cnt++;
      end
      faces[cnt-1].last = 1'b1;
      for (int k = 0; k < cnt; k++) expected_faces.push_back(faces[k]);
    end
    px++;
    if (px >= sx) begin
      px = 0;
      py++;
      if (py >= sy) begin
        py = 0;
        pz++;
        if (pz >= sz) pz = 0;
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", what);
  endtask

  // cell driver: valid holds until the request is taken
  always @(posedge clk) begin
    if (rst) begin
      cell_valid_r <= 1'b0;
      cell_data_r  <= '0;
    end else begin
      if (cell_valid_r && cell_ch.ready) predict_faces(cell_data_r);
      if (!cell_valid_r || cell_ch.ready) begin
        if (cell_pending_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          cell_valid_r <= 1'b1;
          cell_data_r  <= cell_pending_q.pop_front();
        end else begin
          cell_valid_r <= 1'b0;
        end
      end
    end
  end

  // face monitor and receiver back-pressure
  always @(posedge clk) begin : face_mon
    face_rec_t want;
    if (rst) begin
      face_ready_r <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (face_ch.valid && face_ready_r) begin
        if (expected_faces.size() == 0) begin
          report_mismatch($sformatf("unexpected face index %0d value %h",
                                    face_ch.face_index, face_ch.face_value));
        end else begin
          want = expected_faces.pop_front();
          if (face_ch.face_value !== want.value)
            report_mismatch($sformatf("face %0d value %h, want %h",
                                      want.index, face_ch.face_value, want.value));
          if (face_ch.face_index !== want.index)
            report_mismatch($sformatf("face index %0d, want %0d",
                                      face_ch.face_index, want.index));
          if (face_ch.run_last !== want.last)
            report_mismatch($sformatf("face %0d run_last %b, want %b",
                                      want.index, face_ch.run_last, want.last));
        end
      end
      if (hold_kick) stall_left <= HOLD_CYCLES;
      else if (stall_left != 0) stall_left <= stall_left - 1;
      face_ready_r <= !hold_kick && stall_left == 0 &&
                      $urandom_range(0, 99) >= rx_idle_pct;
    end
  end

  task automatic wait_idle();
    while (cell_pending_q.size() != 0 || cell_valid_r || expected_faces.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    tx_idle_pct <= (mode == 0) ? 16 : (mode == 1) ? 88 : 0;
    rx_idle_pct <= (mode == 0) ? 88 : (mode == 1) ? 16 : 0;
  endtask

  // cfg_we stays high across back-to-back writes; apply_grid lowers it
  task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    case (r)
      REG_AXIS:   m_axis = v[1:0];
      REG_SIZE_X: m_sx = SIZE_W'(v);
      REG_SIZE_Y: m_sy = SIZE_W'(v);
      default:    m_sz = SIZE_W'(v);
    endcase
    wr_ptr = '0;
    px = 0;
    py = 0;
    pz = 0;
  endtask

  task automatic apply_grid(input logic [1:0] ax, input logic [SIZE_W-1:0] sx,
                            input logic [SIZE_W-1:0] sy, input logic [SIZE_W-1:0] sz);
    wait_idle();
    write_reg(REG_AXIS, CFG_W'(ax));
    write_reg(REG_SIZE_X, CFG_W'(sx));
    write_reg(REG_SIZE_Y, CFG_W'(sy));
    write_reg(REG_SIZE_Z, CFG_W'(sz));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SW-1:0] rand_q();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return SW'(Q_MAX);
      1:       return SW'(Q_MIN);
      2, 3:    return SW'(int'($urandom_range(0, 1023)) - 512);
      4:       return SW'(Q_MAX) - SW'($urandom_range(0, 3));
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size(input bit allow_big);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return SIZE_W'(0);
    if (r == 1) return SIZE_W'(1);
    if (allow_big && r == 2) return SIZE_W'($urandom_range(64, 127));
    return SIZE_W'($urandom_range(2, 4));
  endfunction

  task automatic random_phase();
    logic [1:0] ax;
    logic [SIZE_W-1:0] sx, sy, sz;
    int r, cnt;
    r = $urandom_range(0, 9);
    ax = (r < 3) ? AXIS_X : (r < 6) ? AXIS_Y : (r < 9) ? AXIS_Z : AXIS_NONE;
    sx = rand_size(1'b0);
    sy = rand_size(1'b0);
    sz = rand_size(1'b1);
    // enough cells along y or z that the delayed neighbor shows up
    cnt = $urandom_range(8, 14);
    if (ax == AXIS_Y) cnt += eff_dim(sx);
    if (ax == AXIS_Z) cnt += eff_dim(sx) * eff_dim(sy);
    apply_grid(ax, sx, sy, sz);
    repeat (cnt) cell_pending_q.push_back(rand_q());
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_idling(0);

    // reset configuration: x axis, 64 cells, saturating first face
    cell_pending_q.push_back(32'h7FFF_FFFF);
    cell_pending_q.push_back(32'h8000_0000);
    cell_pending_q.push_back(32'h7FFF_FFFF);

    // undersized grid clamps to 2x2x2: three faces per row, then wrap
    apply_grid(AXIS_X, 7'd0, 7'd1, 7'd2);
    cell_pending_q.push_back(32'h8000_0000);
    cell_pending_q.push_back(32'h7FFF_FFFF);
    cell_pending_q.push_back(32'h0000_0000);
    cell_pending_q.push_back(32'hFFFF_FFFF);
    cell_pending_q.push_back(32'h0000_0001);
    cell_pending_q.push_back(32'h0000_0002);
    cell_pending_q.push_back(32'h0000_0003);
    cell_pending_q.push_back(32'hFFFF_FFFB);
    cell_pending_q.push_back(32'h1234_5678);

    // axis select 3 makes no faces; oversized sizes clamp
    apply_grid(AXIS_NONE, 7'd127, 7'd1, 7'd65);
    cell_pending_q.push_back(32'h5555_5555);
    cell_pending_q.push_back(32'hAAAA_AAAA);

    apply_grid(AXIS_Y, 7'd2, 7'd2, 7'd2);
    cell_pending_q.push_back(32'h4000_0000);
    cell_pending_q.push_back(32'h7FFF_FFFF);
    cell_pending_q.push_back(32'h4000_0000);
    cell_pending_q.push_back(32'h8000_0000);

    apply_grid(AXIS_Z, 7'd2, 7'd2, 7'd2);
    cell_pending_q.push_back(32'hFFFF_FFFF);
    cell_pending_q.push_back(32'h0000_0001);
    cell_pending_q.push_back(32'h0000_0002);
    cell_pending_q.push_back(32'h0000_0003);
    cell_pending_q.push_back(32'h7FFF_FFFF);
    cell_pending_q.push_back(32'h8000_0000);

    for (int i = 0; i < 12; i++) begin
      wait_idle();
      set_idling(i < 4 ? 0 : (i < 8 ? 1 : 2));
      if (i == 8) begin
        // full-width row; receiver holds off so the block backs up
        apply_grid(AXIS_X, 7'd64, 7'd127, 7'd2);
        repeat (70) cell_pending_q.push_back(rand_q());
        @(posedge clk);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
      end else begin
        random_phase();
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("cell_to_face_velocity_resampler test passed");
    end else begin
      $display("cell_to_face_velocity_resampler test failed");
    end
    $finish;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("cell_to_face_velocity_resampler test failed");
    $finish;
  end

endmodule
